@@ src/bqd_pkg.sv @@
// Shared types, constants and defaults for the biquad low-pass filter.
package bqd_pkg;

  localparam int DEF_SAMPLE_WIDTH   = 16;
  localparam int DEF_COEF_FRAC_BITS = 14;

  // Coefficients are Q2.14 with a fixed 16-bit register width.
  localparam int COEF_WIDTH = 16;
  localparam int REG_IDX_W  = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FEED_0 = 3'd0,
    REG_FEED_1 = 3'd1,
    REG_FEED_2 = 3'd2,
    REG_BACK_1 = 3'd3,
    REG_BACK_2 = 3'd4
  } reg_idx_t;

  typedef logic signed [COEF_WIDTH-1:0] coef_t;

  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } coef_set_t;

  // Butterworth low-pass, 10 Hz corner at 250 Hz sample rate.
  localparam coef_t RST_FEED_0 = 16'sd219;
  localparam coef_t RST_FEED_1 = 16'sd438;
  localparam coef_t RST_FEED_2 = 16'sd219;
  localparam coef_t RST_BACK_1 = -16'sd26992;
  localparam coef_t RST_BACK_2 = 16'sd11483;

endpackage

@@ src/biquad_iir_lowpass.sv @@
// Top level of the second-order direct form I low-pass filter.
//
//   Channel  Direction  Handshake              Payload
//   in_      slave      in_tvalid/in_tready    in_tdata: sample_in
//   out_     master     out_tvalid/out_tready  out_tdata: sample_out, out_tuser: clipped
//   cfg_     slave      cfg_valid/cfg_ready    cfg_index, cfg_data (one coefficient)
//
// One sample is taken per cycle unless a stall backs up to the input. A sample passes
// an input register, a feedforward register and the result register. The feedback
// path (the two output-history products, rounding and saturation) fits in the last
// stage, so the next sample sees the new output history in the very next cycle. Reset
// clears the stage valid bits and both histories and loads the default coefficients.
// A stage holds its sample only while the stage ahead is full and stalled, so empty
// stages keep taking samples while a result waits on out_tready.
module biquad_iir_lowpass import bqd_pkg::*; #(
  parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input samples.
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      in_tdata,   // [SW-1:0] sample_in
  // Filtered samples.
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      out_tdata,  // [SW-1:0] sample_out
  output logic [0:0]                             out_tuser,  // [0] clipped
  // Coefficient writes.
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [REG_IDX_W-1:0]                   cfg_index,
  input  logic [COEF_WIDTH-1:0]                  cfg_data
);

  localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int PROD_W  = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int FF_W    = PROD_W + 2;
  localparam int ACC_W   = PROD_W + 3;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI   =
    ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_LO   = -SAT_HI - ACC_W'(1);

  typedef logic signed [SAMPLE_WIDTH-1:0] smp_t;

  coef_set_t coefs;

  // Handshake and stage movement.
  logic in_xfer;
  logic out_free, ld_out;
  logic s2_free, ld_s2;
  logic s1_free;

  // Stage 1: the new sample and the two before it.
  logic s1_v_r;
  smp_t s1_x0_r, s1_x1_r, s1_x2_r;
  smp_t xh0_r, xh1_r;

  // Stage 2: feedforward sum.
  logic                   s2_v_r;
  logic signed [FF_W-1:0] s2_ff_r;
  logic signed [FF_W-1:0] ff_nxt;
  logic signed [PROD_W-1:0] prod0, prod1, prod2;

  // Result stage and output history.
  logic                    out_v_r;
  logic [SAMPLE_WIDTH-1:0] out_sample_r;
  logic                    out_clip_r;
  smp_t                    yh0_r, yh1_r;
  logic signed [PROD_W-1:0] fb1, fb2;
  logic signed [ACC_W-1:0]  acc, acc_shift;
  smp_t                     y_nxt;
  logic                     clip_nxt;

  bqd_coef_regs u_coef_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs)
  );

  // A stage loads when the stage behind it is full and it is empty or unloading.
  assign out_free  = !out_v_r || out_tready;
  assign ld_out    = s2_v_r && out_free;
  assign s2_free   = !s2_v_r || ld_out;
  assign ld_s2     = s1_v_r && s2_free;
  assign s1_free   = !s1_v_r || ld_s2;
  assign in_tready = s1_free;
  assign in_xfer   = in_tvalid && s1_free;

  // Feedforward part: independent of earlier results, so it runs one stage early.
  assign prod0  = coefs.b0 * s1_x0_r;
  assign prod1  = coefs.b1 * s1_x1_r;
  assign prod2  = coefs.b2 * s1_x2_r;
  assign ff_nxt = FF_W'(prod0) + FF_W'(prod1) + FF_W'(prod2);

  // Feedback part, round half up, then clamp to the sample range.
  assign fb1       = coefs.a1 * yh0_r;
  assign fb2       = coefs.a2 * yh1_r;
  assign acc       = ACC_W'(s2_ff_r) - ACC_W'(fb1) - ACC_W'(fb2);
  assign acc_shift = (acc + RND_HALF) >>> COEF_FRAC_BITS;

  always_comb begin
    priority if (acc_shift > SAT_HI) begin
      y_nxt    = smp_t'(SAT_HI);
      clip_nxt = 1'b1;
    end else if (acc_shift < SAT_LO) begin
      y_nxt    = smp_t'(SAT_LO);
      clip_nxt = 1'b1;
    end else begin
      y_nxt    = smp_t'(acc_shift);
      clip_nxt = 1'b0;
    end
  end

  // Control state and sample histories.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      xh0_r   <= '0;
      xh1_r   <= '0;
      yh0_r   <= '0;
      yh1_r   <= '0;
    end else begin
      if (s1_free) begin
        s1_v_r <= in_tvalid;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (out_free) begin
        out_v_r <= s2_v_r;
      end
      if (in_xfer) begin
        xh0_r <= $signed(in_tdata[SAMPLE_WIDTH-1:0]);
        xh1_r <= xh0_r;
      end
      if (ld_out) begin
        yh0_r <= y_nxt;
        yh1_r <= yh0_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_x0_r <= $signed(in_tdata[SAMPLE_WIDTH-1:0]);
      s1_x1_r <= xh0_r;
      s1_x2_r <= xh1_r;
    end
    if (ld_s2) begin
      s2_ff_r <= ff_nxt;
    end
    if (ld_out) begin
      out_sample_r <= y_nxt;
      out_clip_r   <= clip_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = TDATA_W'(out_sample_r);
  assign out_tuser  = out_clip_r;

endmodule

@@ src/bqd_coef_regs.sv @@
// Coefficient register bank written through the configuration channel.
module bqd_coef_regs import bqd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [COEF_WIDTH-1:0] cfg_data,
  output coef_set_t             coefs
);

  coef_set_t coefs_r;
  coef_set_t coefs_nxt;

  assign cfg_ready = 1'b1;
  assign coefs     = coefs_r;

  // Writes to an index past the last register are dropped.
  always_comb begin
    coefs_nxt = coefs_r;
    if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FEED_0: coefs_nxt.b0 = $signed(cfg_data);
        REG_FEED_1: coefs_nxt.b1 = $signed(cfg_data);
        REG_FEED_2: coefs_nxt.b2 = $signed(cfg_data);
        REG_BACK_1: coefs_nxt.a1 = $signed(cfg_data);
        REG_BACK_2: coefs_nxt.a2 = $signed(cfg_data);
        default:    coefs_nxt = coefs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coefs_r.b0 <= RST_FEED_0;
      coefs_r.b1 <= RST_FEED_1;
      coefs_r.b2 <= RST_FEED_2;
      coefs_r.a1 <= RST_BACK_1;
      coefs_r.a2 <= RST_BACK_2;
    end else begin
      coefs_r <= coefs_nxt;
    end
  end

endmodule

@@ src/bqd_checker.sv @@
// Port-level assertions for the biquad low-pass filter and their bind.
module bqd_checker import bqd_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [((SAMPLE_WIDTH+7)/8)*8-1:0] out_tdata,
  input logic [0:0]                        out_tuser
);

  localparam logic [SAMPLE_WIDTH-1:0] SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Reset empties the pipeline.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // An accepted sample is expected to leave a valid result in the result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##3 out_tvalid)
    else $error("accepted sample did not reach the output");

  // A clipped result sits exactly on one of the sample range bounds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tdata[SAMPLE_WIDTH-1:0] == SMP_MAX || out_tdata[SAMPLE_WIDTH-1:0] == SMP_MIN)
    else $error("clipped flag set on an unsaturated result");

endmodule

bind biquad_iir_lowpass bqd_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_bqd_checker (.*);

@@ bench/biquad_iir_lowpass_tb.sv @@
// Self-checking testbench for the biquad low-pass filter: random stalls, coefficient sweeps.
module biquad_iir_lowpass_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bqd_pkg::*;

  localparam int SW          = DEF_SAMPLE_WIDTH;
  localparam int FRAC        = DEF_COEF_FRAC_BITS;
  localparam int TDATA_W     = ((SW + 7) / 8) * 8;
  localparam int NUM_COEFS   = 5;
  // The run is cut off here even if results are still missing.
  localparam int CYCLE_LIMIT = 400000;
  // Cycles allowed after the last expected result before the block counts as idle.
  localparam int SETTLE      = 8;

  localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  // Shapes of the random sample streams.
  typedef enum {SIG_FULL, SIG_SMALL, SIG_STEP, SIG_RAIL} sig_style_t;
  // Ways the receiver throttles the result stream.
  typedef enum {RX_OPEN, RX_COIN, RX_SLOW, RX_BEAT} rx_mode_t;

  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic                 clipped;
  } filt_result_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata   = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic [0:0]         out_tuser;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_WIDTH-1:0] cfg_data = '0;

  biquad_iir_lowpass uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [15:0] sample_in
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [15:0] sample_out
    .out_tuser  (out_tuser),   // [0] clipped
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: the coefficient file and the two delay lines, mirrored from the block.
  coef_t                coef_model [NUM_COEFS];
  logic signed [SW-1:0] x_hist [2];
  logic signed [SW-1:0] y_hist [2];

  // Samples waiting to be sent and filter outputs waiting to come back.
  logic [SW-1:0] sample_q [$];
  filt_result_t  result_q [$];

  int samples_sent   = 0;
  int results_seen   = 0;
  int clipped_seen   = 0;
  int fail_count     = 0;
  int coef_writes    = 0;
  int coef_settings  = 1;
  int cycle_count    = 0;

  // One step of the direct form I filter. The exact sum is rounded half up, shifted down
  // by the fraction bits and clamped to the sample range; the clamped value feeds back.
  function automatic filt_result_t filter_step(logic signed [SW-1:0] x);
    longint acc;
    longint y;
    longint hi;
    longint lo;
    filt_result_t r;
    hi  = (longint'(1) <<< (SW - 1)) - 1;
    lo  = -hi - 1;
    acc = longint'(coef_model[REG_FEED_0]) * longint'(x)
        + longint'(coef_model[REG_FEED_1]) * longint'(x_hist[0])
        + longint'(coef_model[REG_FEED_2]) * longint'(x_hist[1])
        - longint'(coef_model[REG_BACK_1]) * longint'(y_hist[0])
        - longint'(coef_model[REG_BACK_2]) * longint'(y_hist[1]);
    // Arithmetic shift of a signed value floors, so a tie goes toward plus infinity.
    y = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    r.clipped = 1'b0;
    if (y > hi) begin
      y = hi;
      r.clipped = 1'b1;
    end else if (y < lo) begin
      y = lo;
      r.clipped = 1'b1;
    end
    r.sample  = SW'(y);
    x_hist[1] = x_hist[0];
    x_hist[0] = x;
    y_hist[1] = y_hist[0];
    y_hist[0] = r.sample;
    return r;
  endfunction

  // Sender: bursts of random length separated by random gaps. About one burst in four is
  // followed by no gap at all, so long back-to-back stretches occur too. Every accepted
  // transfer is run through the predictor right at the edge where it happens.
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        result_q.push_back(filter_step(in_tdata[SW-1:0]));
        samples_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left  <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= TDATA_W'(sample_q.pop_front());
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: the throttling mode changes at random intervals, from always ready
  // through coin flips and a mostly stalled mode to a fixed beat.
  rx_mode_t   rx_mode   = RX_OPEN;
  int         mode_left = 0;
  logic [2:0] beat      = '0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_mode    <= RX_OPEN;
      mode_left  <= 0;
      beat       <= '0;
    end else begin
      beat <= beat + 3'd1;
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN: out_tready <= 1'b1;
        RX_COIN: out_tready <= 1'($urandom_range(0, 1));
        RX_SLOW: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= (beat[1:0] != 2'd0);
      endcase
    end
  end

  // Checker: every result transfer is matched against the oldest prediction.
  filt_result_t want;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (result_q.size() == 0) begin
        $error("result with no sample pending: sample_out %0d clipped %0b",
               $signed(out_tdata[SW-1:0]), out_tuser[0]);
        fail_count++;
      end else begin
        want = result_q.pop_front();
        if (want.clipped) clipped_seen++;
        if (out_tdata[SW-1:0] !== want.sample) begin
          $error("sample_out: expected %0d, got %0d", want.sample,
                 $signed(out_tdata[SW-1:0]));
          fail_count++;
        end
        if (out_tuser[0] !== want.clipped) begin
          $error("clipped: expected %0b, got %0b", want.clipped, out_tuser[0]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout with %0d samples unsent and %0d results missing",
             sample_q.size(), result_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // Drives one coefficient write and holds it until the block takes it. The valid is left
  // high so that back-to-back writes need no second assignment in the same step; the
  // caller lowers it after the last write.
  task automatic write_coef(input logic [REG_IDX_W-1:0] idx, input coef_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_COEFS) coef_model[idx] = val;
    coef_writes++;
  endtask

  task automatic load_coefs(input coef_set_t c);
    write_coef(REG_FEED_0, c.b0);
    write_coef(REG_FEED_1, c.b1);
    write_coef(REG_FEED_2, c.b2);
    write_coef(REG_BACK_1, c.a1);
    write_coef(REG_BACK_2, c.a2);
    cfg_valid <= 1'b0;
    coef_settings++;
  endtask

  // Waits until every sample has been sent and every result checked, then lets the
  // pipeline settle before anything else touches the block.
  task automatic drain();
    do @(posedge clk); while (sample_q.size() != 0 || in_tvalid || result_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Random coefficient sets: either anything at all, which mostly saturates, or a
  // low-gain feedforward part with a feedback part close to a usual low-pass.
  function automatic coef_set_t random_coefs(input bit mild);
    coef_set_t c;
    if (mild) begin
      c.b0 = coef_t'($urandom_range(0, 4095)) - 16'sd2048;
      c.b1 = coef_t'($urandom_range(0, 4095)) - 16'sd2048;
      c.b2 = coef_t'($urandom_range(0, 4095)) - 16'sd2048;
      c.a1 = -coef_t'($urandom_range(8000, 30000));
      c.a2 = coef_t'($urandom_range(2000, 14000));
    end else begin
      c.b0 = coef_t'($urandom);
      c.b1 = coef_t'($urandom);
      c.b2 = coef_t'($urandom);
      c.a1 = coef_t'($urandom);
      c.a2 = coef_t'($urandom);
    end
    return c;
  endfunction

  // Random samples come in runs of one shape: full range, small noise, steps held for
  // several samples, or the two rails.
  task automatic queue_random(input int n);
    sig_style_t    style;
    logic [SW-1:0] s;
    s     = '0;
    style = SIG_FULL;
    for (int i = 0; i < n; i++) begin
      if (i % 24 == 0) style = sig_style_t'($urandom_range(0, 3));
      case (style)
        SIG_FULL:  s = SW'($urandom);
        SIG_SMALL: s = SW'(int'($urandom_range(0, 511)) - 256);
        SIG_STEP:  if ($urandom_range(0, 7) == 0) s = SW'($urandom);
        default:   s = $urandom_range(0, 1) ? S_MAX : S_MIN;
      endcase
      sample_q.push_back(s);
    end
  endtask

  initial begin
    coef_model[REG_FEED_0] = RST_FEED_0;
    coef_model[REG_FEED_1] = RST_FEED_1;
    coef_model[REG_FEED_2] = RST_FEED_2;
    coef_model[REG_BACK_1] = RST_BACK_1;
    coef_model[REG_BACK_2] = RST_BACK_2;
    x_hist = '{default: '0};
    y_hist = '{default: '0};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset coefficients: a zero, a positive full-scale step, a negative full-scale step
    // and single LSBs.
    sample_q.push_back('0);
    repeat (5) sample_q.push_back(S_MAX);
    repeat (5) sample_q.push_back(S_MIN);
    sample_q.push_back(SW'(1));
    sample_q.push_back('1);
    queue_random(250);
    drain();

    // Writes to indexes past the last coefficient must leave the file untouched. Then a
    // pure gain of one half, so odd inputs land exactly on a rounding tie.
    for (int k = 0; k < 3; k++) write_coef(REG_IDX_W'(NUM_COEFS + k), coef_t'($urandom));
    load_coefs('{b0: 16'sd8192, b1: '0, b2: '0, a1: '0, a2: '0});
    sample_q.push_back(SW'(1));
    sample_q.push_back(SW'(-1));
    sample_q.push_back(SW'(3));
    sample_q.push_back(SW'(-3));
    sample_q.push_back(S_MAX);
    sample_q.push_back(S_MIN);
    drain();

    // Most negative coefficients everywhere: both clamps are hit.
    load_coefs('{b0: 16'sh8000, b1: 16'sh8000, b2: 16'sh8000, a1: 16'sh8000, a2: 16'sh8000});
    sample_q.push_back(S_MAX);
    sample_q.push_back(S_MIN);
    sample_q.push_back(S_MIN);
    sample_q.push_back('0);
    queue_random(100);
    drain();

    // Most positive coefficients everywhere.
    load_coefs('{b0: 16'sh7fff, b1: 16'sh7fff, b2: 16'sh7fff, a1: 16'sh7fff, a2: 16'sh7fff});
    queue_random(100);
    drain();

    for (int p = 0; p < 4; p++) begin
      load_coefs(random_coefs(p[0]));
      queue_random(140);
      drain();
    end

    // Back to the defaults, loaded through the register port this time.
    load_coefs('{b0: RST_FEED_0, b1: RST_FEED_1, b2: RST_FEED_2,
                 a1: RST_BACK_1, a2: RST_BACK_2});
    queue_random(100);
    drain();

    $display("filtered %0d samples under %0d coefficient sets (%0d register writes)",
             samples_sent, coef_settings, coef_writes);
    $display("checked %0d results, %0d of them saturated, %0d mismatches",
             results_seen, clipped_seen, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
